[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the frame parser rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define SHFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition that must never be seen outside reset
`define SHFP_ASSERT_NEVER(lbl, cond, msg) \
  `SHFP_ASSERT(lbl, !(cond), msg)

`endif

[rtl/shfp_pkg.sv]
// ----------------------------------------------------------------------------
// shfp_pkg
// shared constants and types of the sync header frame parser
// ----------------------------------------------------------------------------
`default_nettype none

package shfp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // register byte addresses
  localparam logic [PADDR_W-1:0] REG_SYNC_FIRST  = 4'h0;
  localparam logic [PADDR_W-1:0] REG_SYNC_SECOND = 4'h4;
  localparam logic [PADDR_W-1:0] REG_FRAME_KIND  = 4'h8;

  // register reset values
  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hA5;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h5A;
  localparam logic [BYTE_W-1:0] FRAME_KIND_RST  = 8'h02;

  // good frame ready in a buffer bank
  typedef struct packed {
    logic valid;
    logic bank;
  } tok_t;

  // buffer bank handed back after its last word is read
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

`default_nettype wire

[rtl/shfp_rx_if.sv]
// ----------------------------------------------------------------------------
// shfp_rx_if
// received byte channel
// ----------------------------------------------------------------------------
`default_nettype none

interface shfp_rx_if
  import shfp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[rtl/shfp_word_if.sv]
// ----------------------------------------------------------------------------
// shfp_word_if
// payload word channel
// ----------------------------------------------------------------------------
`default_nettype none

interface shfp_word_if
  import shfp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] payload_word;
  logic [IDX_W-1:0]  word_index;
  logic              last_word;

  modport source (output valid, output payload_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input payload_word, input word_index,
                  input last_word, output ready);
endinterface

`default_nettype wire

[rtl/shfp_ram.sv]
// ----------------------------------------------------------------------------
// shfp_ram
// simple dual port ram, one write and one registered read
// ----------------------------------------------------------------------------
`default_nettype none

module shfp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 24,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/shfp_queue.sv]
// ----------------------------------------------------------------------------
// shfp_queue
// two entry queue of finished frame banks
// ----------------------------------------------------------------------------
`default_nettype none

module shfp_queue
  import shfp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire tok_t push_i,
  output      logic full_o,
  output      tok_t head_o,
  input  wire logic pop_i
);

  logic [1:0] ent_q;
  logic       wp_q;
  logic       rp_q;
  logic [1:0] cnt_q;

  assign full_o      = (cnt_q == 2'd2);
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.bank  = ent_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i.valid) begin
        ent_q[wp_q] <= push_i.bank;
        wp_q        <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      unique case ({push_i.valid, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/shfp_front.sv]
// ----------------------------------------------------------------------------
// shfp_front
// header hunt, payload capture into the word buffer and checksum test
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module shfp_front
  import shfp_pkg::*;
#(
  parameter int unsigned PAYLOAD_WORDS = 12,
  localparam int unsigned AW = $clog2(2 * PAYLOAD_WORDS),
  localparam int unsigned KW = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  shfp_rx_if.sink                rx_i,
  input  wire logic [BYTE_W-1:0] sync_first_i,
  input  wire logic [BYTE_W-1:0] sync_second_i,
  input  wire logic [BYTE_W-1:0] frame_kind_i,
  output      logic              we_o,
  output      logic [AW-1:0]     waddr_o,
  output      logic [WORD_W-1:0] wdata_o,
  output      tok_t              push_o,
  input  wire logic              q_full_i,
  input  wire rel_t              rel_i
);

  localparam logic [2:0] ST_HUNT = 3'd0;
  localparam logic [2:0] ST_SYNC = 3'd1;
  localparam logic [2:0] ST_KIND = 3'd2;
  localparam logic [2:0] ST_PAY  = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic              wbank_q, wbank_d;
  logic [1:0]        busy_q, busy_d;
  logic [1:0]        lane_q, lane_d;
  logic [KW-1:0]     widx_q, widx_d;
  logic [BYTE_W-1:0] parity_q, parity_d;
  logic [23:0]       asm_q, asm_d;
  logic              accept;
  logic [BYTE_W-1:0] b;

  // payload stalls only while the bank being filled still waits to be read
  assign rx_i.ready = !((state_q == ST_PAY) && busy_q[wbank_q]);
  assign accept     = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;

  assign waddr_o = wbank_q ? (AW'(PAYLOAD_WORDS) + AW'(widx_q)) : AW'(widx_q);
  assign wdata_o = {b, asm_q};

  always_comb begin
    state_d      = state_q;
    wbank_d      = wbank_q;
    lane_d       = lane_q;
    widx_d       = widx_q;
    parity_d     = parity_q;
    asm_d        = asm_q;
    we_o         = 1'b0;
    push_o.valid = 1'b0;
    push_o.bank  = wbank_q;
    if (accept) begin
      unique case (state_q)
        ST_HUNT: begin
          if (b == sync_first_i) state_d = ST_SYNC;
        end
        ST_SYNC: begin
          if (b == sync_second_i)     state_d = ST_KIND;
          else if (b == sync_first_i) state_d = ST_SYNC;
          else                        state_d = ST_HUNT;
        end
        ST_KIND: begin
          if (b == frame_kind_i) begin
            state_d  = ST_PAY;
            parity_d = '0;
            lane_d   = '0;
            widx_d   = '0;
          end else begin
            state_d = ST_HUNT;
          end
        end
        ST_PAY: begin
          parity_d = parity_q ^ b;
          lane_d   = lane_q + 2'd1;
          asm_d    = {b, asm_q[23:8]};
          if (lane_q == 2'd3) begin
            we_o = 1'b1;
            if (widx_q == KW'(PAYLOAD_WORDS - 1)) begin
              widx_d  = '0;
              state_d = ST_CHK;
            end else begin
              widx_d = widx_q + KW'(1);
            end
          end
        end
        ST_CHK: begin
          if (b == parity_q) begin
            push_o.valid = 1'b1;
            wbank_d      = ~wbank_q;
          end
          state_d = ST_HUNT;
        end
        default: state_d = ST_HUNT;
      endcase
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (rel_i.valid)  busy_d[rel_i.bank] = 1'b0;
    if (push_o.valid) busy_d[wbank_q]    = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_HUNT;
      wbank_q  <= 1'b0;
      busy_q   <= '0;
      lane_q   <= '0;
      widx_q   <= '0;
      parity_q <= '0;
    end else begin
      state_q  <= state_d;
      wbank_q  <= wbank_d;
      busy_q   <= busy_d;
      lane_q   <= lane_d;
      widx_q   <= widx_d;
      parity_q <= parity_d;
    end
  end

  always_ff @(posedge clk_i) begin
    asm_q <= asm_d;
  end

  `SHFP_ASSERT(a_push_room, push_o.valid |-> !q_full_i, "frame pushed into a full queue")
  `SHFP_ASSERT(a_write_free, we_o |-> !busy_q[wbank_q], "payload written over a pending bank")

endmodule

`default_nettype wire

[rtl/shfp_back.sv]
// ----------------------------------------------------------------------------
// shfp_back
// reads a finished frame out of the word buffer and emits its words
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module shfp_back
  import shfp_pkg::*;
#(
  parameter int unsigned PAYLOAD_WORDS = 12,
  localparam int unsigned AW = $clog2(2 * PAYLOAD_WORDS),
  localparam int unsigned KW = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tok_t              head_i,
  output      logic              pop_o,
  output      logic              re_o,
  output      logic [AW-1:0]     raddr_o,
  input  wire logic [WORD_W-1:0] rdata_i,
  output      rel_t              rel_o,
  shfp_word_if.source            word_o
);

  logic              busy_q;
  logic              bank_q;
  logic [KW-1:0]     k_q;
  logic              pend_q;
  logic              oval_q;
  logic [WORD_W-1:0] owrd_q;
  logic [IDX_W-1:0]  oidx_q;
  logic              olast_q;
  logic              is_last;

  assign pop_o   = !busy_q && head_i.valid;
  assign re_o    = busy_q && !pend_q && !oval_q;
  assign raddr_o = bank_q ? (AW'(PAYLOAD_WORDS) + AW'(k_q)) : AW'(k_q);
  assign is_last = (k_q == KW'(PAYLOAD_WORDS - 1));

  assign rel_o.valid = pend_q && is_last;
  assign rel_o.bank  = bank_q;

  assign word_o.valid        = oval_q;
  assign word_o.payload_word = owrd_q;
  assign word_o.word_index   = oidx_q;
  assign word_o.last_word    = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bank_q <= 1'b0;
      k_q    <= '0;
      pend_q <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        bank_q <= head_i.bank;
        k_q    <= '0;
      end
      if (re_o) begin
        pend_q <= 1'b1;
      end
      if (pend_q) begin
        pend_q <= 1'b0;
        oval_q <= 1'b1;
        if (is_last) busy_q <= 1'b0;
        else         k_q    <= k_q + KW'(1);
      end else if (oval_q && word_o.ready) begin
        oval_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      owrd_q  <= rdata_i;
      oidx_q  <= IDX_W'(k_q);
      olast_q <= is_last;
    end
  end

  `SHFP_ASSERT_NEVER(a_no_overwrite, pend_q && oval_q, "output word overwritten")
  `SHFP_ASSERT(a_read_in_frame, pend_q |-> busy_q, "buffer read outside a frame")

endmodule

`default_nettype wire

[rtl/sync_header_frame_parser_xor_core.sv]
// a good frame is queued on its checksum byte; its words are read, then registered
// one byte per cycle unless stalled; a word is read once the last one has gone out
// payload bytes stall only while both banks hold good frames not yet fully read
// emission of a frame overlaps with the header and payload of the next one
// reset: async active low, clears control state and restores the sync and type values
// the word buffer itself is not cleared; no clearing pass runs after reset
// ----------------------------------------------------------------------------
// sync_header_frame_parser_xor_core
// two byte sync frame parser with xor payload check, apb register port
// ----------------------------------------------------------------------------
`default_nettype none

module sync_header_frame_parser_xor_core
  import shfp_pkg::*;
#(
  parameter int unsigned PAYLOAD_WORDS = 12
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready,
  // byte in, word out
  shfp_rx_if.sink                 rx_i,
  shfp_word_if.source             word_o
);

  // two banks of payload words: one filling, one draining
  localparam int unsigned DEPTH = 2 * PAYLOAD_WORDS;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [BYTE_W-1:0] sync_first_q;
  logic [BYTE_W-1:0] sync_second_q;
  logic [BYTE_W-1:0] frame_kind_q;
  logic              cfg_wr;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [WORD_W-1:0] rdata;
  tok_t              push;
  tok_t              head;
  logic              q_full;
  logic              pop;
  rel_t              rel;

  // register port: zero wait states, write on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
      frame_kind_q  <= FRAME_KIND_RST;
    end else if (cfg_wr) begin
      // addresses outside the register list are ignored
      unique case (paddr)
        REG_SYNC_FIRST:  sync_first_q  <= pwdata[BYTE_W-1:0];
        REG_SYNC_SECOND: sync_second_q <= pwdata[BYTE_W-1:0];
        REG_FRAME_KIND:  frame_kind_q  <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      REG_SYNC_FIRST:  prdata = PDATA_W'(sync_first_q);
      REG_SYNC_SECOND: prdata = PDATA_W'(sync_second_q);
      REG_FRAME_KIND:  prdata = PDATA_W'(frame_kind_q);
      default:         prdata = '0;
    endcase
  end

  // front: header hunt, word packing, checksum
  shfp_front #(
    .PAYLOAD_WORDS (PAYLOAD_WORDS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_i          (rx_i),
    .sync_first_i  (sync_first_q),
    .sync_second_i (sync_second_q),
    .frame_kind_i  (frame_kind_q),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .push_o        (push),
    .q_full_i      (q_full),
    .rel_i         (rel)
  );

  // payload word buffer, bank 0 in the low half
  shfp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // good frames waiting for the back end
  shfp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  // back: word readout and output register
  shfp_back #(
    .PAYLOAD_WORDS (PAYLOAD_WORDS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .pop_o   (pop),
    .re_o    (re),
    .raddr_o (raddr),
    .rdata_i (rdata),
    .rel_o   (rel),
    .word_o  (word_o)
  );

endmodule

`default_nettype wire
